@@ rtl/core/offset_indexed_vector_store_assert.svh @@
// Assertion macros for the offset indexed vector store
`ifndef OFFSET_INDEXED_VECTOR_STORE_ASSERT_SVH
`define OFFSET_INDEXED_VECTOR_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OVS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ovs assertion failed");
`define OVS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ovs assertion failed");
`else
`define OVS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define OVS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/ovs_pkg.sv @@
// Shared types and constants for the offset indexed vector store
package ovs_pkg;

    localparam int CNT_W = 7;
    localparam int VAL_W = 32;
    localparam int IDX_W = 16;
    localparam int POS_W = 17;

    typedef enum logic [2:0] {
        OP_PUSH         = 3'd0,
        OP_POP          = 3'd1,
        OP_INSERT       = 3'd2,
        OP_REMOVE       = 3'd3,
        OP_REMOVE_RANGE = 3'd4,
        OP_ACCESS       = 3'd5,
        OP_READ_RANGE   = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    load;
        logic    wr_push;
        logic    wr_pos;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_sub;
        logic    start_up;
        logic    start_down;
        logic    rd_pos;
        logic    rd_step;
        logic    mv_wr;
        logic    out_ld;
        logic    out_use_rd;
        status_t out_status;
        logic    out_last;
    } ovs_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       we;
        logic       full;
        logic       empty;
        logic       rd_ok;
        logic       ins_ok;
        logic       range_ok;
        logic       left_zero;
        logic       out_free;
    } ovs_stat_t;

endpackage

@@ rtl/core/ovs_ctrl.sv @@
// Sequencing state machine for the offset indexed vector store
module ovs_ctrl
    import ovs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ovs_stat_t stat,
    output ovs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INS_MOVE,
        S_INS_FIN,
        S_RM_MOVE,
        S_RR_EMIT,
        S_RESP
    } state_t;

    state_t  state_reg, state_next;
    status_t resp_status_reg, resp_status_next;
    logic    resp_rd_reg, resp_rd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            resp_status_reg <= ST_OK;
            resp_rd_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            resp_status_reg <= resp_status_next;
            resp_rd_reg     <= resp_rd_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd              = '0;
        state_next       = state_reg;
        resp_status_next = resp_status_reg;
        resp_rd_next     = resp_rd_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next       = S_RESP;
                resp_status_next = ST_OK;
                resp_rd_next     = 1'b0;
                unique case (stat.op)
                    OP_PUSH: begin
                        if (stat.full) begin
                            resp_status_next = ST_FULL;
                        end else begin
                            cmd.wr_push = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (!stat.empty) begin
                            cmd.cnt_dec = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (!stat.ins_ok) begin
                            resp_status_next = ST_RANGE;
                        end else if (stat.full) begin
                            resp_status_next = ST_FULL;
                        end else begin
                            cmd.start_up = 1'b1;
                            state_next   = S_INS_MOVE;
                        end
                    end
                    OP_REMOVE: begin
                        if (!stat.rd_ok) begin
                            resp_status_next = ST_RANGE;
                        end else begin
                            cmd.start_down = 1'b1;
                            state_next     = S_RM_MOVE;
                        end
                    end
                    OP_REMOVE_RANGE: begin
                        if (!stat.range_ok) begin
                            resp_status_next = ST_RANGE;
                        end else begin
                            cmd.start_down = 1'b1;
                            state_next     = S_RM_MOVE;
                        end
                    end
                    OP_ACCESS: begin
                        if (!stat.rd_ok) begin
                            resp_status_next = ST_RANGE;
                        end else if (stat.we) begin
                            cmd.wr_pos = 1'b1;
                        end else begin
                            cmd.rd_pos   = 1'b1;
                            resp_rd_next = 1'b1;
                        end
                    end
                    OP_READ_RANGE: begin
                        if (!stat.range_ok) begin
                            resp_status_next = ST_RANGE;
                        end else begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_RR_EMIT;
                        end
                    end
                    default: begin
                        resp_status_next = ST_RANGE;
                    end
                endcase
            end
            S_INS_MOVE: begin
                if (!stat.left_zero) begin
                    cmd.rd_step = 1'b1;
                    cmd.mv_wr   = 1'b1;
                end else begin
                    state_next = S_INS_FIN;
                end
            end
            S_INS_FIN: begin
                cmd.wr_pos  = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_RESP;
            end
            S_RM_MOVE: begin
                if (!stat.left_zero) begin
                    cmd.rd_step = 1'b1;
                    cmd.mv_wr   = 1'b1;
                end else begin
                    cmd.cnt_sub = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_RR_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_use_rd = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_last   = stat.left_zero;
                    if (!stat.left_zero) begin
                        cmd.rd_step = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_use_rd = resp_rd_reg;
                    cmd.out_status = resp_status_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ovs_dpath.sv @@
// Element memory, count, address counters and result register of the vector store
`include "offset_indexed_vector_store_assert.svh"
module ovs_dpath
    import ovs_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic signed [IDX_W-1:0] cfg_data,
    input  logic [2:0]              s_opcode,
    input  logic                    s_write_enable,
    input  logic signed [IDX_W-1:0] s_index,
    input  logic signed [IDX_W-1:0] s_index_end,
    input  logic signed [VAL_W-1:0] s_value,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic signed [VAL_W-1:0] m_data,
    output logic [1:0]              m_status,
    output logic [CNT_W-1:0]        m_count,
    output logic                    m_last,
    input  ovs_cmd_t                cmd,
    output ovs_stat_t               stat
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic signed [IDX_W-1:0] base_reg;
    logic [2:0]              op_reg;
    logic                    we_reg;
    logic signed [POS_W-1:0] pos_reg, pend_reg;
    logic [DATA_WIDTH-1:0]   val_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [AW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic [CNT_W-1:0]        span_reg;
    logic                    dir_up_reg;
    logic                    mv_pend_reg;
    logic [AW-1:0]           mv_wa_reg;
    logic [DATA_WIDTH-1:0]   rd_data_reg;
    logic                    m_valid_reg;
    logic [VAL_W-1:0]        m_data_reg;
    status_t                 m_status_reg;
    logic [CNT_W-1:0]        m_count_reg;
    logic                    m_last_reg;

    logic signed [POS_W-1:0]      cnt_s;
    logic [CNT_W-1:0]             end_pos, span, cnt_m1;
    logic                         rd_en, wr_en, out_free;
    logic [AW-1:0]                rd_addr, wr_addr;
    logic [DATA_WIDTH-1:0]        wr_data;
    logic signed [DATA_WIDTH-1:0] rd_s;
    logic [VAL_W-1:0]             rd_ext;

    assign cnt_s   = $signed({{(POS_W - CNT_W){1'b0}}, count_reg});
    assign end_pos = (op_reg == OP_REMOVE) ? pos_reg[CNT_W-1:0] + CNT_W'(1)
                                           : pend_reg[CNT_W-1:0];
    assign span    = end_pos - pos_reg[CNT_W-1:0];
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign rd_s    = rd_data_reg;
    assign rd_ext  = VAL_W'(rd_s);

    assign out_free = !m_valid_reg || m_ready;

    assign stat.op        = op_reg;
    assign stat.we        = we_reg;
    assign stat.full      = (count_reg >= CAP_C);
    assign stat.empty     = (count_reg == '0);
    assign stat.rd_ok     = !pos_reg[POS_W-1] && (pos_reg < cnt_s);
    assign stat.ins_ok    = !pos_reg[POS_W-1] && (pos_reg <= cnt_s);
    assign stat.range_ok  = !pos_reg[POS_W-1] && (pend_reg > pos_reg) && (pend_reg <= cnt_s);
    assign stat.left_zero = (left_reg == '0);
    assign stat.out_free  = out_free;

    // memory ports
    assign rd_en   = cmd.rd_pos || cmd.rd_step;
    assign rd_addr = cmd.rd_pos ? pos_reg[AW-1:0] : rd_ptr_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = mv_wa_reg;
        wr_data = rd_data_reg;
        if (mv_pend_reg) begin
            wr_en = 1'b1;
        end else if (cmd.wr_push) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_data = val_reg;
        end else if (cmd.wr_pos) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg[AW-1:0];
            wr_data = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // address and move counters
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        left_next   = left_reg;
        if (cmd.start_up) begin
            rd_ptr_next = cnt_m1[AW-1:0];
            left_next   = count_reg - pos_reg[CNT_W-1:0];
        end else if (cmd.start_down) begin
            rd_ptr_next = end_pos[AW-1:0];
            left_next   = count_reg - end_pos;
        end else if (cmd.rd_pos) begin
            rd_ptr_next = pos_reg[AW-1:0] + AW'(1);
            left_next   = span - CNT_W'(1);
        end else if (cmd.rd_step) begin
            rd_ptr_next = dir_up_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
            left_next   = left_reg - CNT_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.cnt_sub) begin
            count_next = count_reg - span_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            count_reg   <= '0;
            mv_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            count_reg   <= count_next;
            mv_pend_reg <= cmd.rd_step && cmd.mv_wr;
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            we_reg   <= s_write_enable;
            pos_reg  <= $signed({s_index[IDX_W-1], s_index})
                        - $signed({base_reg[IDX_W-1], base_reg});
            pend_reg <= $signed({s_index_end[IDX_W-1], s_index_end})
                        - $signed({base_reg[IDX_W-1], base_reg});
            val_reg  <= DATA_WIDTH'($unsigned(s_value));
        end
        rd_ptr_reg <= rd_ptr_next;
        left_reg   <= left_next;
        if (cmd.start_up) begin
            dir_up_reg <= 1'b1;
        end else if (cmd.start_down || cmd.rd_pos) begin
            dir_up_reg <= 1'b0;
        end
        if (cmd.start_down) begin
            span_reg <= span;
        end
        if (cmd.rd_step) begin
            mv_wa_reg <= dir_up_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - span_reg[AW-1:0];
        end
        if (cmd.out_ld) begin
            m_data_reg   <= cmd.out_use_rd ? rd_ext : '0;
            m_status_reg <= cmd.out_status;
            m_count_reg  <= count_reg;
            m_last_reg   <= cmd.out_last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;
    assign m_last   = m_last_reg;

    `OVS_ASSERT_IMPL(a_wr_no_clash, aclk, aresetn, mv_pend_reg, !(cmd.wr_push || cmd.wr_pos))
    `OVS_ASSERT_IMPL(a_count_cap, aclk, aresetn, 1'b1, count_reg <= CAP_C)
    `OVS_ASSERT_IMPL(a_ld_free, aclk, aresetn, cmd.out_ld, out_free)
    `OVS_ASSERT_NEXT(a_push_grows, aclk, aresetn, cmd.wr_push, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

@@ rtl/core/offset_indexed_vector_store.sv @@
// Offset indexed vector store: ordered element store with insert, remove and range read
//
// Items arrive on the s_ channel (valid/ready) and results leave on the m_ channel.
// The cfg channel writes base_index, the logical index of position 0; it is always
// ready and must only be used while the block is idle.
// Each item gives one result beat with m_last set, except a valid range read, which
// gives one beat per element read, m_last on the final one.
// After an item is accepted it is checked in S_CHECK; its result beat is loaded from
// S_RESP, or from S_RR_EMIT for a range read. A valid insert first moves the elements
// from pos upward in S_INS_MOVE and writes the value in S_INS_FIN; a valid remove first
// moves the elements above the removed span down in S_RM_MOVE.
// A new item is taken only in S_IDLE, once the result of the item before is loaded.
// The element memory (one read and one write a cycle) sets the rate of one moved or read
// element per cycle; range read beats go out at that rate only while m_ready is high.
// Reset clears the element count and base_index; element contents stay undefined.
// When m_ready is low the output register holds the beat and the sequencer waits.
module offset_indexed_vector_store
    import ovs_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic signed [IDX_W-1:0] cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_opcode,
    input  logic                    s_write_enable,
    input  logic signed [IDX_W-1:0] s_index,
    input  logic signed [IDX_W-1:0] s_index_end,
    input  logic signed [VAL_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_data,
    output logic [1:0]              m_status,
    output logic [CNT_W-1:0]        m_count,
    output logic                    m_last
);

    ovs_cmd_t  cmd;
    ovs_stat_t stat;

    assign cfg_ready = 1'b1;

    ovs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ovs_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_opcode       (s_opcode),
        .s_write_enable (s_write_enable),
        .s_index        (s_index),
        .s_index_end    (s_index_end),
        .s_value        (s_value),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_data         (m_data),
        .m_status       (m_status),
        .m_count        (m_count),
        .m_last         (m_last),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
